// ===== src/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
`default_nettype none

package spq_pkg;

    // Action codes carried in a request.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Status codes carried in a result.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // One incoming request.
    typedef struct packed {
        logic               action;
        logic signed [31:0] value;
        logic        [7:0]  priority_req;
    } t_in;

    // One outgoing result.
    typedef struct packed {
        logic        [1:0]  status;
        logic signed [31:0] out_value;
        logic        [7:0]  out_priority;
        logic        [3:0]  count;
    } t_out;

    // Contents of one storage cell.
    typedef struct packed {
        logic               valid;
        logic signed [31:0] value;
        logic        [7:0]  prio;
    } t_entry;

    // Operation broadcast to every cell in a cycle.
    typedef struct packed {
        logic               ins;
        logic               rem;
        logic signed [31:0] value;
        logic        [7:0]  prio;
    } t_op;

endpackage

`default_nettype wire

// ===== src/sorted_priority_queue_core.sv =====
// Top level of the sorted priority queue: cell chain, count and result register.
//
//   Channel  Direction  Handshake                    Payload
//   in       input      i_in_valid / o_in_stall      i_in_data  (spq_pkg::t_in)
//   out      output     o_out_valid / i_out_stall    o_out_data (spq_pkg::t_out)
//
// One request is taken per cycle unless held off by stall; its result is registered and appears in the next cycle.
// Every cell compares and shifts in parallel, so the clock period is set by
// one 8-bit compare per cell plus the neighbor select.
// Reset clears all valid flags, the count and the output valid flag.
// While a result waits under stall, no new request is taken.
`default_nettype none

module sorted_priority_queue_core #(
    parameter int CAPACITY = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire spq_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output spq_pkg::t_out      o_out_data
);

    localparam int CntW = $clog2(CAPACITY + 1);

    spq_pkg::t_entry   w_ent  [0:CAPACITY];
    logic              w_keep [0:CAPACITY];
    spq_pkg::t_op      w_op;
    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    logic [CntW-1:0]   r_count;
    logic [CntW-1:0]   n_count;
    logic [CntW+3:0]   w_count_ext;
    logic              r_out_valid;
    spq_pkg::t_out     r_out_data;
    spq_pkg::t_out     n_out_data;

    // Handshake: hold off requests while a result is stuck.
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_full      = (r_count == CntW'(CAPACITY));
    assign w_empty     = (r_count == '0);

    // Operation broadcast to the cells.
    always_comb begin
        w_op.ins   = w_accept && (i_in_data.action == spq_pkg::ACT_INSERT) && !w_full;
        w_op.rem   = w_accept && (i_in_data.action == spq_pkg::ACT_REMOVE) && !w_empty;
        w_op.value = i_in_data.value;
        w_op.prio  = i_in_data.priority_req;
    end

    // Chain ends: the head sees a keeping neighbor, the tail sees an empty slot.
    assign w_keep[0]       = 1'b1;
    assign w_ent[CAPACITY] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_pkg::t_entry w_prev;
        if (g == 0) begin : g_head
            assign w_prev = '0;
        end else begin : g_body
            assign w_prev = w_ent[g-1];
        end
        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_op        (w_op),
            .i_prev      (w_prev),
            .i_prev_keep (w_keep[g]),
            .i_next      (w_ent[g+1]),
            .o_entry     (w_ent[g]),
            .o_keep      (w_keep[g+1])
        );
    end

    // Next count and the result of this request.
    always_comb begin
        n_count = r_count;
        if (w_op.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_op.rem) begin
            n_count = r_count - 1'b1;
        end
        w_count_ext             = {4'b0000, n_count};
        n_out_data.count        = w_count_ext[3:0];
        n_out_data.out_value    = '0;
        n_out_data.out_priority = '0;
        n_out_data.status       = spq_pkg::ST_DONE;
        if (i_in_data.action == spq_pkg::ACT_INSERT) begin
            if (w_full) begin
                n_out_data.status = spq_pkg::ST_FULL;
            end
        end else if (w_empty) begin
            n_out_data.status = spq_pkg::ST_EMPTY;
        end else begin
            n_out_data.out_value    = w_ent[0].value;
            n_out_data.out_priority = w_ent[0].prio;
        end
    end

    // Count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== src/spq_cell.sv =====
// One slot of the sorted store; shifts toward head or tail with its neighbors.
`default_nettype none

module spq_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire spq_pkg::t_op    i_op,
    input  wire spq_pkg::t_entry i_prev,
    input  wire logic            i_prev_keep,
    input  wire spq_pkg::t_entry i_next,
    output spq_pkg::t_entry      o_entry,
    output logic                 o_keep
);

    logic               r_valid;
    logic signed [31:0] r_value;
    logic        [7:0]  r_prio;
    spq_pkg::t_entry    n_entry;
    logic               w_load;

    // A cell stays put on insert when its entry ranks equal or higher.
    assign o_keep = r_valid && (r_prio >= i_op.prio);

    assign o_entry.valid = r_valid;
    assign o_entry.value = r_value;
    assign o_entry.prio  = r_prio;

    // Pick the new content: hold, take the new entry, or shift from a neighbor.
    always_comb begin
        n_entry = o_entry;
        w_load  = 1'b0;
        if (i_op.ins && !o_keep) begin
            w_load = 1'b1;
            if (i_prev_keep) begin
                n_entry.valid = 1'b1;
                n_entry.value = i_op.value;
                n_entry.prio  = i_op.prio;
            end else begin
                n_entry = i_prev;
            end
        end else if (i_op.rem) begin
            w_load  = 1'b1;
            n_entry = i_next;
        end
    end

    // Valid flag is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= n_entry.valid;
        end
    end

    // Payload carries no reset; an invalid slot is never read out.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_value <= n_entry.value;
            r_prio  <= n_entry.prio;
        end
    end

endmodule

`default_nettype wire
